@@ sv/scrq_pkg.sv @@
package scrq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int HANDLE_BITS_DEF = 32;
  localparam int DESC_BITS       = 32;

  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_COMMIT   = 3'd2,
    OP_UNCOMMIT = 3'd3,
    OP_CLEAR    = 3'd4
  } opcode_t;

  typedef struct packed {
    opcode_t                opcode;
    logic [DESC_BITS-1:0]   descriptor_in;
  } in_item_t;

  typedef struct packed {
    logic                   accepted;
    logic [DESC_BITS-1:0]   descriptor_out;
    logic                   is_full;
    logic                   is_empty;
    logic                   is_dirty;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clr;
  } slot_ctl_t;

endpackage

@@ sv/scrq_slot_store.sv @@
module scrq_slot_store #(
  parameter int DEPTH = scrq_pkg::QUEUE_DEPTH_DEF,
  parameter int WIDTH = scrq_pkg::DESC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  scrq_pkg::slot_ctl_t      ctl,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  import scrq_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[raddr];
      rd_vld_r  <= vld_r[raddr];
    end
  end

  // invalid slots read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.clr) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  assign rdata = rd_vld_r ? rd_data_r : '0;

endmodule

@@ sv/staged_commit_ring_queue_core.sv @@
// An accepted transaction is registered in stage A (a_vld_r, a_item_r), then in
// the output register (out_vld_r, out_r). Throughput: one transaction per cycle
// while out_stall is low; the pointer logic and one slot memory access per
// transaction set this, with a two-deep register pipeline.
// Reset (rst_n low, synchronous): head and both tails go to 0, every slot reads
// as zero, the pipeline empties and out_valid drops.
module staged_commit_ring_queue_core #(
  parameter int QUEUE_DEPTH = scrq_pkg::QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = scrq_pkg::HANDLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  scrq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output scrq_pkg::out_item_t out_data
);
  import scrq_pkg::*;

  localparam int IDX_BITS   = $clog2(QUEUE_DEPTH);
  localparam int STORE_BITS = (HANDLE_BITS < DESC_BITS) ? HANDLE_BITS : DESC_BITS;
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(QUEUE_DEPTH - 1);

  function automatic logic [IDX_BITS-1:0] ring_next(input logic [IDX_BITS-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  logic [IDX_BITS-1:0]   head_r, head_nxt;
  logic [IDX_BITS-1:0]   ctail_r, ctail_nxt;
  logic [IDX_BITS-1:0]   stail_r, stail_nxt;
  logic                  a_vld_r;
  logic                  a_pop_r;
  out_item_t             a_item_r;
  out_item_t             a_item_nxt;
  logic                  out_vld_r;
  out_item_t             out_r;
  out_item_t             out_nxt;
  logic                  a_ready;
  logic                  b_ready;
  logic                  in_fire;
  logic                  pop_ok;
  slot_ctl_t             ctl_raw;
  slot_ctl_t             slot_ctl;
  logic [STORE_BITS-1:0] rdata;

  assign b_ready  = !out_vld_r || !out_stall;
  assign a_ready  = !a_vld_r || b_ready;
  assign in_stall = !a_ready;
  assign in_fire  = in_valid && a_ready;

  always_comb begin
    head_nxt   = head_r;
    ctail_nxt  = ctail_r;
    stail_nxt  = stail_r;
    pop_ok     = 1'b0;
    ctl_raw    = '0;
    a_item_nxt = '0;
    a_item_nxt.accepted = 1'b1;
    case (in_data.opcode)
      OP_PUSH: begin
        if (ring_next(ctail_r) == head_r) begin
          a_item_nxt.accepted = 1'b0;
        end else begin
          ctl_raw.wr_en = 1'b1;
          stail_nxt     = ring_next(ctail_r);
        end
      end
      OP_POP: begin
        if (head_r == ctail_r) begin
          a_item_nxt.accepted = 1'b0;
        end else begin
          ctl_raw.rd_en = 1'b1;
          pop_ok        = 1'b1;
          head_nxt      = ring_next(head_r);
        end
      end
      OP_COMMIT: begin
        ctail_nxt = stail_r;
      end
      OP_UNCOMMIT: begin
        stail_nxt = ctail_r;
      end
      OP_CLEAR: begin
        head_nxt    = '0;
        ctail_nxt   = '0;
        stail_nxt   = '0;
        ctl_raw.clr = 1'b1;
      end
      default: begin
      end
    endcase
    a_item_nxt.is_full  = (ring_next(stail_nxt) == head_nxt);
    a_item_nxt.is_empty = (ctail_nxt == head_nxt);
    a_item_nxt.is_dirty = (stail_nxt != ctail_nxt);
  end

  assign slot_ctl = in_fire ? ctl_raw : '0;

  scrq_slot_store #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (STORE_BITS)
  ) u_slots (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (slot_ctl),
    .waddr (ctail_r),
    .wdata (in_data.descriptor_in[STORE_BITS-1:0]),
    .raddr (head_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      ctail_r <= '0;
      stail_r <= '0;
    end else if (in_fire) begin
      head_r  <= head_nxt;
      ctail_r <= ctail_nxt;
      stail_r <= stail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_ready) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_item_r <= a_item_nxt;
      a_pop_r  <= pop_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (b_ready) begin
      out_vld_r <= a_vld_r;
    end
  end

  always_comb begin
    out_nxt                = a_item_r;
    out_nxt.descriptor_out = a_pop_r ? DESC_BITS'(rdata) : '0;
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_vld_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_stage_follows_commit : assert property (@(posedge clk) disable iff (!rst_n)
    (stail_r != ctail_r) |-> (stail_r == ring_next(ctail_r)))
    else $error("staged tail not one past committed tail");

  a_stage_not_head : assert property (@(posedge clk) disable iff (!rst_n)
    (stail_r != ctail_r) |-> (stail_r != head_r))
    else $error("staged slot overlaps head");

  a_refused_no_data : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.accepted) |-> (out_r.descriptor_out == '0))
    else $error("refused transaction carries a descriptor");

  a_clear_resets_ptrs : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.opcode == OP_CLEAR)) |=>
      ((head_r == '0) && (ctail_r == '0) && (stail_r == '0)))
    else $error("clear left pointers set");

endmodule
